@@ hw/rtl/borf_pkg.sv @@
// shared types and constants for the box obstacle repulsion block
package borf_pkg;

  localparam int MaxObstacles = 16;
  localparam int SlotW = 4;
  localparam int CountW = 5;
  localparam logic [16:0] MinDistReset = 17'd655;

  // item kinds
  localparam logic [1:0] KindObstacle = 2'd0;
  localparam logic [1:0] KindPosition = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;

  // one table entry
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } box_t;

  // start of a divide and its result
  typedef struct packed {
    logic        go;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

@@ hw/rtl/box_obstacle_repulsion_force.sv @@
// box obstacle repulsion force, top level
// Usage: drive kind and the item fields with start high while busy is low.
// An obstacle item writes one of 16 table slots (slot 16+ impossible with 4
// bits), a position item replaces the vehicle position. A tick walks the 16
// slots one at a time. A valid slot reads its box from the table memory,
// finds the gaps, runs a square root and then four passes per axis through
// a shared 64-step divider; a far box is left before the square root. The
// sums then take two more divides by the slot count and one item is shown
// on force_x, force_y and saturated with done high for one cycle. A tick
// with an empty table ends with no item. Busy stays high throughout a tick
// and the next item is taken as soon as busy falls. Results cannot be held
// off; the receiver must take them.
// min_distance may be written when busy is low; zero acts as one.
// Reset clears the valid bits, the position and min_distance to 655.
module box_obstacle_repulsion_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [3:0]         slot,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic               saturated
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_READ, S_GAP, S_SQR, S_SQRT, S_DIST, S_CUBE,
    S_DA, S_DB, S_DC, S_DD, S_ACC, S_NEXT, S_AVGX, S_AVGY, S_OUT
  } state_t;

  state_t state;
  logic [16:0] min_distance;
  logic [borf_pkg::MaxObstacles-1:0] slot_valid;
  logic signed [31:0] vehicle_x, vehicle_y;
  logic [borf_pkg::SlotW-1:0] idx;
  logic [borf_pkg::CountW-1:0] count;
  logic axis;
  borf_pkg::box_t rbox;
  logic accept;

  logic [32:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic far;
  logic [63:0] sq;
  logic [63:0] rad;
  logic [63:0] root;
  logic [5:0] scnt;
  logic [31:0] radius;
  logic [63:0] q1;
  logic [63:0] term;
  logic signed [63:0] sum_x, sum_y;
  logic sum_neg;
  borf_pkg::div_req_t dreq;
  borf_pkg::div_rsp_t drsp;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  borf_table u_table (
    .clk  (clk),
    .we   (accept && kind == borf_pkg::KindObstacle),
    .waddr(slot),
    .wdata({box_min_x, box_min_y, box_max_x, box_max_y}),
    .raddr(idx),
    .rdata(rbox)
  );

  borf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // gap per axis
  function automatic logic [33:0] gap(input logic signed [31:0] lo,
                                      input logic signed [31:0] hi,
                                      input logic signed [31:0] pos);
    logic signed [32:0] a, b, g;
    a = 33'(lo) - 33'(pos);
    b = 33'(pos) - 33'(hi);
    g = (a > b) ? a : b;
    if (g < 0) g = '0;
    gap = {(g == a) && (g != 0), g};
  endfunction

  logic [33:0] gx, gy;
  assign gx = gap(rbox.min_x, rbox.max_x, vehicle_x);
  assign gy = gap(rbox.min_y, rbox.max_y, vehicle_y);

  // sqrt step
  logic [63:0] sbit;
  logic [63:0] strial;
  assign sbit = 64'd1 << {scnt[4:0], 1'b0};
  assign strial = root + sbit;

  logic [16:0] mind;
  assign mind = (min_distance == '0) ? 17'd1 : min_distance;

  // saturation of averaged value
  function automatic logic [32:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat = {1'b1, 32'h7fffffff};
    else if (v < -64'sd2147483648) sat = {1'b1, 32'h80000000};
    else sat = {1'b0, v[31:0]};
  endfunction

  logic signed [63:0] signed_q;
  logic [32:0] sat_r;
  assign signed_q = sum_neg ? -$signed(drsp.quo) : $signed(drsp.quo);
  assign sat_r = sat(signed_q);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      min_distance <= borf_pkg::MinDistReset;
      slot_valid <= '0;
      vehicle_x <= '0;
      vehicle_y <= '0;
      done <= 1'b0;
      dreq.go <= 1'b0;
    end else begin
      done <= 1'b0;
      dreq.go <= 1'b0;
      if (cfg_we) min_distance <= cfg_data;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              borf_pkg::KindObstacle: slot_valid[slot] <= 1'b1;
              borf_pkg::KindPosition: begin
                vehicle_x <= new_x;
                vehicle_y <= new_y;
              end
              borf_pkg::KindTick: begin
                idx <= '0;
                count <= '0;
                sum_x <= '0;
                sum_y <= '0;
                saturated <= 1'b0;
                state <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: state <= slot_valid[idx] ? S_READ : S_NEXT;
        S_READ: begin
          count <= count + 1'b1;
          state <= S_GAP;
        end
        S_GAP: begin
          mag_x <= gx[32:0];
          neg_x <= gx[33];
          mag_y <= gy[32:0];
          neg_y <= gy[33];
          far <= (gx[32:24] != 0) || (gy[32:24] != 0);
          state <= S_SQR;
        end
        S_SQR: begin
          if (far) state <= S_NEXT;
          else begin
            sq <= 64'(mag_x[23:0]) * 64'(mag_x[23:0]);
            rad <= 64'(mag_y[23:0]) * 64'(mag_y[23:0]);
            state <= S_SQRT;
            scnt <= 6'd32;
            root <= '0;
          end
        end
        S_SQRT: begin
          if (scnt == 6'd32) begin
            rad <= sq + rad;
            scnt <= 6'd31;
          end else begin
            if (rad >= strial) begin
              rad <= rad - strial;
              root <= (root >> 1) + sbit;
            end else root <= root >> 1;
            if (scnt == 6'd0) state <= S_DIST;
            scnt <= scnt - 6'd1;
          end
        end
        S_DIST: begin
          radius <= (root[31:0] < 32'(mind)) ? 32'(mind) : root[31:0];
          axis <= 1'b0;
          state <= S_CUBE;
        end
        S_CUBE: begin
          dreq.num <= {16'd0, (axis ? mag_y[23:0] : mag_x[23:0]), 24'd0};
          dreq.den <= 64'(radius);
          dreq.go <= 1'b1;
          state <= S_DA;
        end
        S_DA: if (drsp.done) begin
          q1 <= drsp.quo << 24;
          dreq.num <= drsp.rem << 24;
          dreq.go <= 1'b1;
          state <= S_DB;
        end
        S_DB: if (drsp.done) begin
          dreq.num <= q1 + drsp.quo;
          dreq.go <= 1'b1;
          state <= S_DC;
        end
        S_DC: if (drsp.done) begin
          dreq.num <= drsp.quo;
          dreq.go <= 1'b1;
          state <= S_DD;
        end
        S_DD: if (drsp.done) begin
          term <= drsp.quo;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!axis) begin
            sum_x <= neg_x ? sum_x - $signed(term) : sum_x + $signed(term);
            axis <= 1'b1;
            state <= S_CUBE;
          end else begin
            sum_y <= neg_y ? sum_y - $signed(term) : sum_y + $signed(term);
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          idx <= idx + 1'b1;
          if (idx == borf_pkg::SlotW'(borf_pkg::MaxObstacles - 1)) begin
            if (count == '0) state <= S_IDLE;
            else begin
              axis <= 1'b0;
              state <= S_AVGX;
              dreq.num <= sum_x[63] ? 64'(-sum_x) : 64'(sum_x);
              dreq.den <= 64'(count);
              sum_neg <= sum_x[63];
              dreq.go <= 1'b1;
            end
          end else state <= S_SCAN;
        end
        S_AVGX: if (drsp.done) begin
          force_x <= sat_r[31:0];
          saturated <= sat_r[32];
          axis <= 1'b1;
          dreq.num <= sum_y[63] ? 64'(-sum_y) : 64'(sum_y);
          sum_neg <= sum_y[63];
          dreq.go <= 1'b1;
          state <= S_AVGY;
        end
        S_AVGY: if (drsp.done) begin
          force_y <= sat_r[31:0];
          saturated <= saturated | sat_r[32];
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> busy) else $error("output state not busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_AVGX) |-> count != '0) else $error("average with empty count");
`endif

endmodule

@@ hw/rtl/borf_div.sv @@
// shared restoring divider, one quotient bit per cycle
module borf_div (
  input  logic               clk,
  input  logic               rst,
  input  borf_pkg::div_req_t req,
  output borf_pkg::div_rsp_t rsp
);

  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        run;
  logic        fin;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, den};

  // shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
        cnt <= 7'd64;
      end else if (run) begin
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: fin, quo: quo, rem: rem[63:0]};

endmodule

@@ hw/rtl/borf_table.sv @@
// obstacle box memory with a registered read port
module borf_table (
  input  logic                         clk,
  input  logic                         we,
  input  logic [borf_pkg::SlotW-1:0]   waddr,
  input  borf_pkg::box_t               wdata,
  input  logic [borf_pkg::SlotW-1:0]   raddr,
  output borf_pkg::box_t               rdata
);

  borf_pkg::box_t mem [borf_pkg::MaxObstacles];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the box obstacle repulsion force block
module tb_top;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam longint CycleLimit = 64'd20_000_000;
  localparam int RandItems = 1650;

  // one row of directed stimulus
  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic signed [31:0] bmin_x, bmin_y, bmax_x, bmax_y, px, py;
    bit                 typed;
    logic signed [31:0] fx, fy;
    logic               sat;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] fx, fy;
    logic               sat;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = borf_pkg::KindObstacle;
  logic [3:0] slot = '0;
  logic signed [31:0] box_min_x = '0, box_min_y = '0, box_max_x = '0, box_max_y = '0;
  logic signed [31:0] new_x = '0, new_y = '0;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;
  logic done;
  logic signed [31:0] force_x, force_y;
  logic saturated;

  box_obstacle_repulsion_force i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .slot(slot),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_max_x(box_max_x),
    .box_max_y(box_max_y), .new_x(new_x), .new_y(new_y), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(done), .force_x(force_x), .force_y(force_y),
    .saturated(saturated)
  );

  always #5 clk = ~clk;

  // shadow state of the block
  bit                 shadow_valid [borf_pkg::MaxObstacles];
  borf_pkg::box_t     shadow_box [borf_pkg::MaxObstacles];
  logic signed [31:0] shadow_px, shadow_py;
  logic [16:0]        shadow_mind;

  force_t force_queue[$];
  int fails = 0;
  int n_items = 0, n_ticks = 0, n_forces = 0, n_sat = 0;
  longint cycles = 0;

  // values typed into the directed table for the item in flight
  bit                 row_typed = 1'b0;
  force_t             row_force;

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // signed gap of the vehicle to one axis span
  function automatic void axis_gap(longint lo, longint hi, longint pos,
                                   output logic [63:0] mag, output bit neg);
    longint a, b, g;
    a = lo - pos;
    b = pos - hi;
    g = (a > b) ? a : b;
    if (g < 0) g = 0;
    neg = (g == a) && (g != 0);
    mag = g;
  endfunction

  // magnitude * 2^48 / d^3, truncated
  function automatic logic [63:0] inv_cube(logic [63:0] mag, logic [63:0] d);
    logic [63:0] num, q, r, q1;
    num = mag << 24;
    q = num / d;
    r = num % d;
    q1 = (q << 24) + ((r << 24) / d);
    return (q1 / d) / d;
  endfunction

  function automatic bit repulsion(output force_t f);
    longint sum_x, sum_y, cnt, ax, ay, tx, ty;
    logic [63:0] mx, my, d, mind;
    bit nx, ny;
    sum_x = 0;
    sum_y = 0;
    cnt = 0;
    f.sat = 1'b0;
    mind = (shadow_mind == 0) ? 64'd1 : 64'(shadow_mind);
    for (int i = 0; i < borf_pkg::MaxObstacles; i++) begin
      if (shadow_valid[i]) begin
        cnt++;
        axis_gap(shadow_box[i].min_x, shadow_box[i].max_x, shadow_px, mx, nx);
        axis_gap(shadow_box[i].min_y, shadow_box[i].max_y, shadow_py, my, ny);
        if (mx < (64'd1 << 24) && my < (64'd1 << 24)) begin
          d = int_sqrt(mx * mx + my * my);
          if (d < mind) d = mind;
          tx = inv_cube(mx, d);
          ty = inv_cube(my, d);
          sum_x += nx ? -tx : tx;
          sum_y += ny ? -ty : ty;
        end
      end
    end
    if (cnt == 0) return 1'b0;
    ax = sum_x / cnt;
    ay = sum_y / cnt;
    if (ax > 64'sd2147483647) begin ax = 64'sd2147483647; f.sat = 1'b1; end
    if (ax < -64'sd2147483648) begin ax = -64'sd2147483648; f.sat = 1'b1; end
    if (ay > 64'sd2147483647) begin ay = 64'sd2147483647; f.sat = 1'b1; end
    if (ay < -64'sd2147483648) begin ay = -64'sd2147483648; f.sat = 1'b1; end
    f.fx = ax[31:0];
    f.fy = ay[31:0];
    return 1'b1;
  endfunction

  // shadow update on accepted items and register writes
  always @(posedge clk) begin
    force_t f;
    force_t expect_f;
    cycles <= cycles + 1;
    if (rst) begin
      for (int i = 0; i < borf_pkg::MaxObstacles; i++) shadow_valid[i] = 1'b0;
      shadow_px = 0;
      shadow_py = 0;
      shadow_mind = borf_pkg::MinDistReset;
    end else begin
      if (cfg_we) shadow_mind = cfg_data;
      if (start && !busy) begin
        n_items++;
        case (kind)
          borf_pkg::KindObstacle: begin
            shadow_box[slot] = '{box_min_x, box_min_y, box_max_x, box_max_y};
            shadow_valid[slot] = 1'b1;
          end
          borf_pkg::KindPosition: begin
            shadow_px = new_x;
            shadow_py = new_y;
          end
          borf_pkg::KindTick: begin
            n_ticks++;
            if (repulsion(f)) begin
              expect_f = row_typed ? row_force : f;
              force_queue = {force_queue, expect_f};
              n_forces++;
              if (f.sat) n_sat++;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    force_t e;
    if (!rst && done) begin
      if (force_queue.size() == 0) begin
        $error("unexpected force item: %0d %0d %0d", force_x, force_y, saturated);
        fails++;
      end else begin
        e = force_queue.pop_front();
        if (force_x !== e.fx) begin
          $error("force_x expected %0d actual %0d", e.fx, force_x);
          fails++;
        end
        if (force_y !== e.fy) begin
          $error("force_y expected %0d actual %0d", e.fy, force_y);
          fails++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, saturated);
          fails++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // drive one item, return at the edge where it is taken
  task automatic send_item(stim_row_t r);
    row_typed <= r.typed;
    row_force <= '{r.fx, r.fy, r.sat};
    start <= 1'b1;
    kind <= r.kind;
    slot <= r.slot;
    box_min_x <= r.bmin_x;
    box_min_y <= r.bmin_y;
    box_max_x <= r.bmax_x;
    box_max_y <= r.bmax_y;
    new_x <= r.px;
    new_y <= r.py;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 99) < 50) ? 0 :
        ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(20, 300);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (busy || force_queue.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_min_dist(logic [16:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random coordinate, mostly near the origin
  function automatic logic signed [31:0] near_coord();
    logic signed [31:0] v;
    if ($urandom_range(0, 99) < 15) return $urandom;
    v = $urandom_range(0, (1 << $urandom_range(0, 22)));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int p, half;
    r = '{default: '0};
    p = $urandom_range(0, 99);
    r.kind = (p < 45) ? borf_pkg::KindObstacle : (p < 78) ? borf_pkg::KindPosition :
             (p < 95) ? borf_pkg::KindTick : KindUnused;
    r.slot = 4'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      r.bmin_x = shadow_px + near_coord();
      r.bmin_y = shadow_py + near_coord();
      half = $urandom_range(0, (1 << $urandom_range(0, 20)));
      r.bmax_x = ($urandom_range(0, 9) == 0) ? r.bmin_x - half : r.bmin_x + half;
      r.bmax_y = r.bmin_y + $urandom_range(0, (1 << $urandom_range(0, 20)));
    end else begin
      r.bmin_x = $urandom;
      r.bmin_y = $urandom;
      r.bmax_x = $urandom;
      r.bmax_y = $urandom;
    end
    r.px = near_coord();
    r.py = near_coord();
    return r;
  endfunction

  // directed items: empty tick, unused kind, gaps outside, inside, far,
  // extreme positions, inverted box, last slot
  stim_row_t directed [] = '{
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0},
    '{KindUnused, 4'd0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindObstacle, 4'd0, 65536, -65536, 131072, 65536, 0, 0,
      1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b1, -65536, 0, 1'b0},
    '{borf_pkg::KindObstacle, 4'd0, -65536, -65536, 65536, 65536, 0, 0,
      1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0},
    '{borf_pkg::KindObstacle, 4'd15, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
      32'h80000000, 0, 0, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0},
    '{borf_pkg::KindPosition, 4'd0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff,
      1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0},
    '{borf_pkg::KindPosition, 4'd0, 0, 0, 0, 0, 196608, 0, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b1, 8192, 0, 1'b0},
    '{borf_pkg::KindObstacle, 4'd3, 65536, 65536, -65536, -65536, 0, 0,
      1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindPosition, 4'd0, 0, 0, 0, 0, 1, -1, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindObstacle, 4'd5, 2, 0, 2, 0, 0, 0, 1'b0, 0, 0, 1'b0},
    '{borf_pkg::KindTick, 4'd0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0}
  };

  initial begin
    logic [16:0] settings [6];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_item(directed[i]);
      random_gap();
    end
    row_typed <= 1'b0;

    // random phases under several clamp settings, extremes included
    settings = '{17'd1, 17'd0, 17'd131071, 17'd65536, borf_pkg::MinDistReset, 17'd0};
    settings[5] = 17'($urandom);
    foreach (settings[k]) begin
      write_min_dist(settings[k]);
      for (int n = 0; n < RandItems / 6; n++) begin
        send_item(random_row());
        if (n % 50 == 49) wait_idle();
        else random_gap();
      end
    end

    wait_idle();
    repeat (400) @(posedge clk);
    $display("ran %0d items with %0d ticks; %0d force items, %0d saturated",
             n_items, n_ticks, n_forces, n_sat);
    $display("clamp settings swept: 0, 1, 655, 65536, 131071 and one random value");
    if (fails == 0 && force_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
